FILE: hdl/tksd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksd_pkg
// Shared types, codes and sizes of the terminal keyboard/screen device.
// ----------------------------------------------------------------------------
package tksd_pkg;

	// line geometry
	localparam int LINE_MAX = 64;
	localparam int IDX_W    = $clog2(LINE_MAX);
	localparam int LS_W     = 7;
	localparam int CHAR_W   = 8;

	// character codes
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
	localparam logic [CHAR_W-1:0] CH_NONE    = 8'd0;

	// smallest usable line size
	localparam logic [LS_W-1:0] LS_MIN = 7'd3;

	// function codes carried with each item
	typedef enum logic [2:0] {
		FUNC_READ  = 3'd0,
		FUNC_WRITE = 3'd1,
		FUNC_KEY   = 3'd2,
		FUNC_TICK  = 3'd3,
		FUNC_CLEAR = 3'd4,
		FUNC_PEEK  = 3'd5
	} func_t;

	// register indexes
	typedef enum logic [1:0] {
		REG_KEY_DATA  = 2'd0,
		REG_KEY_STAT  = 2'd1,
		REG_SCR_DATA  = 2'd2,
		REG_SCR_STAT  = 2'd3
	} reg_t;

	// result status
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BUSY    = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	// screen mode
	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_SCROLL = 2'd1,
		MODE_CLEAR  = 2'd2
	} mode_t;

	// control sequencer phase
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_EXEC = 2'd1,
		PH_FORM = 2'd2
	} phase_t;

	// operation broadcast to the row of screen cells
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_SHIFT  = 2'd1,
		CELL_PUT    = 2'd2,
		CELL_SCROLL = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [IDX_W-1:0]  pos;
		logic [CHAR_W-1:0] wr_char;
		logic [IDX_W-1:0]  peek_pos;
	} cell_ctrl_t;

endpackage

FILE: hdl/tksd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tksd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/tksd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksd_cell
// One screen character cell; takes its right neighbor on shift, or at pos on scroll.
// ----------------------------------------------------------------------------
module tksd_cell (
	input  logic                              clk,
	input  logic [tksd_pkg::IDX_W-1:0]        idx,
	input  tksd_pkg::cell_ctrl_t              ctrl,
	input  logic [tksd_pkg::CHAR_W-1:0]       right_data,
	output logic [tksd_pkg::CHAR_W-1:0]       data,
	output logic [tksd_pkg::CHAR_W-1:0]       peek_data
);

	logic [tksd_pkg::CHAR_W-1:0] data_q;
	logic [tksd_pkg::CHAR_W-1:0] data_d;
	logic                        at_pos;
	logic                        after_pos;

	// position decode: this cell, or the one right after the target
	assign at_pos    = (idx == ctrl.pos);
	assign after_pos = ({1'b0, idx} == ({1'b0, ctrl.pos} + (tksd_pkg::IDX_W+1)'(1)));

	// next character
	always_comb begin
		data_d = data_q;
		unique case (ctrl.op)
			tksd_pkg::CELL_HOLD: begin
				data_d = data_q;
			end
			tksd_pkg::CELL_SHIFT: begin
				data_d = right_data;
			end
			tksd_pkg::CELL_PUT: begin
				if (at_pos) begin
					data_d = ctrl.wr_char;
				end
			end
			tksd_pkg::CELL_SCROLL: begin
				if (at_pos) begin
					data_d = right_data;
				end else if (after_pos) begin
					data_d = tksd_pkg::CH_SPACE;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	// read-back contribution, or-ed across the row
	assign data      = data_q;
	assign peek_data = (idx == ctrl.peek_pos) ? data_q : tksd_pkg::CH_NONE;

endmodule

FILE: hdl/terminal_keyboard_screen_device_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_keyboard_screen_device_core
// Terminal with keyboard queue and one-line screen behind four registers.
//
// channel  | dir | fields (lsb first)
// s_       | in  | tuser: func; tdata: reg_index, write_value, key_char, peek_pos
// m_       | out | tdata: read_value, status, screen_char, screen_length,
//          |     |        keys_waiting, screen_mode
// cfg_     | in  | line_size write, no read-back
//
// Each item passes through accept, state update and result forming, the
// phases of the three-phase sequencer; the keyboard RAM read is registered.
// The next item is accepted while a result waits on m_; a stall on m_ holds
// the sequencer in its forming phase. Reset clears all control state and sets
// line_size to 64; screen cells and queue RAM need no clearing.
// ----------------------------------------------------------------------------
module terminal_keyboard_screen_device_core (
	input  logic        clk,
	input  logic        arst_n,
	// transfer in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // reg_index[1:0], write_value[9:2], key_char[17:10],
	                              // peek_pos[23:18]
	input  logic [2:0]  s_tuser,  // func[2:0]
	// transfer out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // read_value[7:0], status[9:8], screen_char[17:10],
	                              // screen_length[23:18], keys_waiting[29:24],
	                              // screen_mode[31:30]
	// configuration
	input  logic        cfg_wen,
	input  logic [6:0]  cfg_wdata
);

	localparam int IDX_W  = tksd_pkg::IDX_W;
	localparam int CHAR_W = tksd_pkg::CHAR_W;
	localparam int LS_W   = tksd_pkg::LS_W;
	localparam int LMAX   = tksd_pkg::LINE_MAX;

	// sequencer and state
	tksd_pkg::phase_t   phase_q, phase_d;
	tksd_pkg::mode_t    mode_q, mode_d;
	logic [IDX_W-1:0]   key_head_q, key_head_d;
	logic [IDX_W-1:0]   key_count_q, key_count_d;
	logic [IDX_W-1:0]   screen_len_q, screen_len_d;
	logic [IDX_W-1:0]   scroll_pos_q, scroll_pos_d;
	logic [LS_W-1:0]    line_size_q;
	logic [LS_W-1:0]    eff_size;

	// captured item
	logic [2:0]         func_q;
	logic [1:0]         reg_index_q;
	logic [CHAR_W-1:0]  write_value_q;
	logic [CHAR_W-1:0]  key_char_q;
	logic [IDX_W-1:0]   peek_pos_q;

	// per-item results
	logic [CHAR_W-1:0]  read_value_q, read_value_d;
	tksd_pkg::status_t  status_q, status_d;

	// output register
	logic               m_tvalid_q;
	logic [31:0]        m_tdata_q;
	logic               out_free;
	logic               out_load;

	// keyboard ram
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [CHAR_W-1:0]  ram_rdata;
	logic [IDX_W:0]     tail_sum;
	logic [IDX_W-1:0]   key_tail;

	// screen cell row
	tksd_pkg::cell_ctrl_t cell_ctrl;
	logic [CHAR_W-1:0]  cell_data [LMAX];
	logic [CHAR_W-1:0]  cell_peek [LMAX];
	logic [CHAR_W-1:0]  peek_or;
	logic [CHAR_W-1:0]  screen_char;

	logic               s_accept;

	assign s_tready = (phase_q == tksd_pkg::PH_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (phase_q == tksd_pkg::PH_FORM) && out_free;

	// effective line size, saturated to the supported range
	always_comb begin
		if (line_size_q < tksd_pkg::LS_MIN) begin
			eff_size = tksd_pkg::LS_MIN;
		end else if (line_size_q > LS_W'(LMAX)) begin
			eff_size = LS_W'(LMAX);
		end else begin
			eff_size = line_size_q;
		end
	end

	// queue tail with ring wrap
	assign tail_sum = {1'b0, key_head_q} + {1'b0, key_count_q};
	always_comb begin
		if (tail_sum >= (IDX_W+1)'(LMAX)) begin
			key_tail = IDX_W'(tail_sum - (IDX_W+1)'(LMAX));
		end else begin
			key_tail = tail_sum[IDX_W-1:0];
		end
	end
	assign ram_waddr = key_tail;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_size_q <= LS_W'(LMAX);
		end else if (cfg_wen) begin
			line_size_q <= cfg_wdata;
		end
	end

	// capture the accepted item
	always_ff @(posedge clk) begin
		if (s_accept) begin
			func_q        <= s_tuser;
			reg_index_q   <= s_tdata[1:0];
			write_value_q <= s_tdata[9:2];
			key_char_q    <= s_tdata[17:10];
			peek_pos_q    <= s_tdata[23:18];
		end
	end

	// sequencer next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			tksd_pkg::PH_IDLE: begin
				if (s_accept) begin
					phase_d = tksd_pkg::PH_EXEC;
				end
			end
			tksd_pkg::PH_EXEC: begin
				phase_d = tksd_pkg::PH_FORM;
			end
			tksd_pkg::PH_FORM: begin
				if (out_free) begin
					phase_d = tksd_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_d = tksd_pkg::PH_IDLE;
			end
		endcase
	end

	// state update for the item in the execute phase
	always_comb begin
		key_head_d        = key_head_q;
		key_count_d       = key_count_q;
		screen_len_d      = screen_len_q;
		scroll_pos_d      = scroll_pos_q;
		mode_d            = mode_q;
		read_value_d      = read_value_q;
		status_d          = status_q;
		ram_we            = 1'b0;
		cell_ctrl.op      = tksd_pkg::CELL_HOLD;
		cell_ctrl.pos     = screen_len_q;
		cell_ctrl.wr_char = write_value_q;
		cell_ctrl.peek_pos = peek_pos_q;
		if (phase_q == tksd_pkg::PH_EXEC) begin
			read_value_d = tksd_pkg::CH_NONE;
			status_d     = tksd_pkg::ST_OK;
			unique case (func_q)
				tksd_pkg::FUNC_READ: begin
					unique case (reg_index_q)
						tksd_pkg::REG_KEY_DATA: begin
							if (key_count_q == '0) begin
								status_d = tksd_pkg::ST_BUSY;
							end else begin
								read_value_d = ram_rdata;
								key_count_d  = key_count_q - IDX_W'(1);
								if (key_head_q == IDX_W'(LMAX - 1)) begin
									key_head_d = '0;
								end else begin
									key_head_d = key_head_q + IDX_W'(1);
								end
							end
						end
						tksd_pkg::REG_KEY_STAT: begin
							read_value_d = CHAR_W'(key_count_q != '0);
						end
						tksd_pkg::REG_SCR_DATA: begin
							status_d = tksd_pkg::ST_INVALID;
						end
						tksd_pkg::REG_SCR_STAT: begin
							read_value_d = CHAR_W'(mode_q == tksd_pkg::MODE_NORMAL);
						end
						default: begin
							status_d = tksd_pkg::ST_INVALID;
						end
					endcase
				end
				tksd_pkg::FUNC_WRITE: begin
					if (reg_index_q != tksd_pkg::REG_SCR_DATA) begin
						status_d = tksd_pkg::ST_INVALID;
					end else if (mode_q != tksd_pkg::MODE_NORMAL) begin
						status_d = tksd_pkg::ST_BUSY;
					end else if (write_value_q == tksd_pkg::CH_NEWLINE) begin
						mode_d = tksd_pkg::MODE_CLEAR;
					end else if (write_value_q != tksd_pkg::CH_NONE) begin
						// append at the end of the line, scroll when one short of the line size
						cell_ctrl.op = tksd_pkg::CELL_PUT;
						screen_len_d = screen_len_q + IDX_W'(1);
						if (({2'b00, screen_len_q} + (IDX_W+2)'(2)) >=
						    {{(IDX_W+2-LS_W){1'b0}}, eff_size}) begin
							mode_d       = tksd_pkg::MODE_SCROLL;
							scroll_pos_d = '0;
						end
					end
				end
				tksd_pkg::FUNC_KEY: begin
					if ((key_char_q != tksd_pkg::CH_NONE) &&
					    (({2'b00, key_count_q} + (IDX_W+2)'(2)) <
					     {{(IDX_W+2-LS_W){1'b0}}, eff_size})) begin
						ram_we      = 1'b1;
						key_count_d = key_count_q + IDX_W'(1);
					end
				end
				tksd_pkg::FUNC_TICK: begin
					if (mode_q == tksd_pkg::MODE_SCROLL) begin
						if (({1'b0, scroll_pos_q} + (IDX_W+1)'(1)) < {1'b0, screen_len_q}) begin
							cell_ctrl.op  = tksd_pkg::CELL_SCROLL;
							cell_ctrl.pos = scroll_pos_q;
							scroll_pos_d  = scroll_pos_q + IDX_W'(1);
						end else begin
							if (scroll_pos_q < screen_len_q) begin
								screen_len_d = scroll_pos_q;
							end
							mode_d = tksd_pkg::MODE_NORMAL;
						end
					end else if (mode_q == tksd_pkg::MODE_CLEAR) begin
						// drop the leading character
						if (screen_len_q != '0) begin
							cell_ctrl.op = tksd_pkg::CELL_SHIFT;
							screen_len_d = screen_len_q - IDX_W'(1);
						end
						if (screen_len_q <= IDX_W'(1)) begin
							mode_d = tksd_pkg::MODE_NORMAL;
						end
					end
				end
				tksd_pkg::FUNC_CLEAR: begin
					screen_len_d = '0;
					mode_d       = tksd_pkg::MODE_NORMAL;
				end
				tksd_pkg::FUNC_PEEK: begin
					status_d = tksd_pkg::ST_OK;
				end
				default: begin
					status_d = tksd_pkg::ST_INVALID;
				end
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= tksd_pkg::PH_IDLE;
			mode_q       <= tksd_pkg::MODE_NORMAL;
			key_head_q   <= '0;
			key_count_q  <= '0;
			screen_len_q <= '0;
			scroll_pos_q <= '0;
		end else begin
			phase_q      <= phase_d;
			mode_q       <= mode_d;
			key_head_q   <= key_head_d;
			key_count_q  <= key_count_d;
			screen_len_q <= screen_len_d;
			scroll_pos_q <= scroll_pos_d;
		end
	end

	// per-item result registers
	always_ff @(posedge clk) begin
		read_value_q <= read_value_d;
		status_q     <= status_d;
	end

	// keyboard queue storage
	tksd_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (LMAX)
	) u_key_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (key_char_q),
		.raddr (key_head_q),
		.rdata (ram_rdata)
	);

	// row of screen cells, each fed by its right neighbor, the last by itself
	for (genvar i = 0; i < LMAX; i++) begin : g_cell
		logic [CHAR_W-1:0] right_data;
		if (i == LMAX - 1) begin : g_last
			assign right_data = cell_data[i];
		end else begin : g_mid
			assign right_data = cell_data[i+1];
		end
		tksd_cell u_cell (
			.clk        (clk),
			.idx        (IDX_W'(i)),
			.ctrl       (cell_ctrl),
			.right_data (right_data),
			.data       (cell_data[i]),
			.peek_data  (cell_peek[i])
		);
	end

	// gather the peeked character across the row
	always_comb begin
		peek_or = tksd_pkg::CH_NONE;
		for (int i = 0; i < LMAX; i++) begin
			peek_or = peek_or | cell_peek[i];
		end
	end
	assign screen_char = (peek_pos_q < screen_len_q) ? peek_or : tksd_pkg::CH_NONE;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {mode_q, key_count_q, screen_len_q, screen_char,
			              status_q, read_value_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: verif/tb_terminal_keyboard_screen_device_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_terminal_keyboard_screen_device_core
// Self-checking bench for the terminal keyboard/screen device. A queue-fed
// driver offers register accesses, key presses, ticks, clears and peeks on the
// input stream. A model of the keyboard ring, the screen line and
// its scroll/clear modes predicts one reply per accepted transfer, and the
// monitor compares every reply field by field in order. The line size is
// changed between phases, across its extremes, while the block is idle.
// ----------------------------------------------------------------------------
module tb_terminal_keyboard_screen_device_core;

	// func codes with no operation behind them
	localparam logic [2:0] FUNC_UNUSED_6 = 3'd6;
	localparam logic [2:0] FUNC_UNUSED_7 = 3'd7;

	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 48;

	typedef struct packed {
		logic [2:0]       func;
		logic [5:0]       peek;
		logic [7:0]       key;
		logic [7:0]       wr;
		tksd_pkg::reg_t   reg_idx;
	} access_t;

	// same layout as m_tdata, msb first
	typedef struct packed {
		tksd_pkg::mode_t   md;
		logic [5:0]        keys;
		logic [5:0]        len;
		logic [7:0]        scr;
		tksd_pkg::status_t st;
		logic [7:0]        rd;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_wen = 1'b0;
	logic [6:0]  cfg_wdata = '0;

	access_t access_q[$];
	reply_t  reply_q[$];

	int tx_idle_pct = 21;
	int rx_idle_pct = 50;
	int hold_req = 0;
	int rx_hold_seen = 0;
	int rx_hold_left = 0;
	int err_count = 0;
	bit in_taken = 1'b0;

	// terminal state as the model sees it
	logic [7:0]      kq[tksd_pkg::LINE_MAX];
	logic [7:0]      line_buf[tksd_pkg::LINE_MAX];
	int unsigned     khead = 0;
	int unsigned     kcount = 0;
	int unsigned     slen = 0;
	int unsigned     spos = 0;
	tksd_pkg::mode_t smode = tksd_pkg::MODE_NORMAL;
	int unsigned     lsize = 64;

	terminal_keyboard_screen_device_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned eff_line(int unsigned ls);
		if (ls < 3) return 3;
		if (ls > tksd_pkg::LINE_MAX) return tksd_pkg::LINE_MAX;
		return ls;
	endfunction

	// apply one access to the terminal state and form its reply
	function automatic reply_t term_update(access_t a);
		reply_t r;
		int unsigned eff;
		int unsigned old;
		r = '0;
		r.st = tksd_pkg::ST_OK;
		r.md = tksd_pkg::MODE_NORMAL;
		eff = eff_line(lsize);
		case (a.func)
			tksd_pkg::FUNC_READ: begin
				case (a.reg_idx)
					tksd_pkg::REG_KEY_DATA: begin
						if (kcount == 0) begin
							r.st = tksd_pkg::ST_BUSY;
						end else begin
							r.rd = kq[khead];
							khead = (khead + 1) % tksd_pkg::LINE_MAX;
							kcount--;
						end
					end
					tksd_pkg::REG_KEY_STAT: r.rd = (kcount != 0) ? 8'd1 : 8'd0;
					tksd_pkg::REG_SCR_DATA: r.st = tksd_pkg::ST_INVALID;
					default: r.rd = (smode == tksd_pkg::MODE_NORMAL) ? 8'd1 : 8'd0;
				endcase
			end
			tksd_pkg::FUNC_WRITE: begin
				if (a.reg_idx != tksd_pkg::REG_SCR_DATA) begin
					r.st = tksd_pkg::ST_INVALID;
				end else if (smode != tksd_pkg::MODE_NORMAL) begin
					r.st = tksd_pkg::ST_BUSY;
				end else if (a.wr == tksd_pkg::CH_NEWLINE) begin
					smode = tksd_pkg::MODE_CLEAR;
				end else if (a.wr != tksd_pkg::CH_NONE && slen < tksd_pkg::LINE_MAX) begin
					line_buf[slen] = a.wr;
					slen++;
					if (slen + 1 >= eff) begin
						smode = tksd_pkg::MODE_SCROLL;
						spos = 0;
					end
				end
			end
			tksd_pkg::FUNC_KEY: begin
				if (a.key != tksd_pkg::CH_NONE && kcount + 2 < eff &&
				    kcount < tksd_pkg::LINE_MAX) begin
					kq[(khead + kcount) % tksd_pkg::LINE_MAX] = a.key;
					kcount++;
				end
			end
			tksd_pkg::FUNC_TICK: begin
				if (smode == tksd_pkg::MODE_SCROLL) begin
					if (spos + 1 < slen) begin
						line_buf[spos] = line_buf[spos + 1];
						spos++;
						line_buf[spos] = tksd_pkg::CH_SPACE;
					end else begin
						if (spos < slen) slen = spos;
						smode = tksd_pkg::MODE_NORMAL;
					end
				end else if (smode == tksd_pkg::MODE_CLEAR) begin
					old = slen;
					if (old > 0) begin
						for (int i = 0; i + 1 < old; i++) line_buf[i] = line_buf[i + 1];
						slen = old - 1;
					end
					if (old <= 1) smode = tksd_pkg::MODE_NORMAL;
				end
			end
			tksd_pkg::FUNC_CLEAR: begin
				slen = 0;
				smode = tksd_pkg::MODE_NORMAL;
			end
			tksd_pkg::FUNC_PEEK: ;
			default: r.st = tksd_pkg::ST_INVALID;
		endcase
		if (a.peek < slen) r.scr = line_buf[a.peek];
		r.len = slen[5:0];
		r.keys = kcount[5:0];
		r.md = smode;
		return r;
	endfunction

	task automatic flag_field(input string fname, input logic [7:0] e, input logic [7:0] g);
		err_count++;
		if (err_count <= 10)
			$display("mismatch %s at %0t: expected %0d got %0d", fname, $realtime, e, g);
	endtask

	// input side: next transfer after an accept or an idle cycle
	always @(negedge clk) begin : drive_in
		access_t nxt;
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (access_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				nxt = access_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {nxt.peek, nxt.key, nxt.wr, nxt.reg_idx};
				s_tuser  <= nxt.func;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output side: random stalls plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_req != rx_hold_seen) begin
			rx_hold_seen = hold_req;
			rx_hold_left = HOLD_CYCLES;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// predict on each input transfer, check each output transfer
	always @(posedge clk) begin : watch
		access_t a;
		reply_t got;
		reply_t want;
		in_taken = arst_n && s_tvalid && s_tready;
		if (in_taken) begin
			a.func    = s_tuser;
			a.reg_idx = tksd_pkg::reg_t'(s_tdata[1:0]);
			a.wr      = s_tdata[9:2];
			a.key     = s_tdata[17:10];
			a.peek    = s_tdata[23:18];
			reply_q.push_back(term_update(a));
		end
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			got = reply_t'(m_tdata);
			if (reply_q.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected transfer at %0t: %h", $realtime, m_tdata);
			end else begin
				want = reply_q.pop_front();
				if (got.rd !== want.rd) flag_field("read_value", want.rd, got.rd);
				if (got.st !== want.st)
					flag_field("status", 8'(want.st), 8'(got.st));
				if (got.scr !== want.scr) flag_field("screen_char", want.scr, got.scr);
				if (got.len !== want.len)
					flag_field("screen_length", 8'(want.len), 8'(got.len));
				if (got.keys !== want.keys)
					flag_field("keys_waiting", 8'(want.keys), 8'(got.keys));
				if (got.md !== want.md)
					flag_field("screen_mode", 8'(want.md), 8'(got.md));
			end
		end
	end

	function automatic access_t any_access();
		access_t a;
		a.func    = 3'($urandom_range(0, 7));
		a.reg_idx = tksd_pkg::reg_t'($urandom_range(0, 3));
		a.wr      = 8'($urandom_range(0, 255));
		a.key     = 8'($urandom_range(0, 255));
		a.peek    = 6'($urandom_range(0, 63));
		return a;
	endfunction

	task automatic add_access(input logic [2:0] f, input tksd_pkg::reg_t r,
			input logic [7:0] w, input logic [7:0] k, input logic [5:0] p);
		access_t a;
		a.func = f;
		a.reg_idx = r;
		a.wr = w;
		a.key = k;
		a.peek = p;
		access_q.push_back(a);
	endtask

	// bursts of like operations with random content, some noise mixed in
	task automatic add_random(input int n);
		access_t a;
		int k;
		int kind;
		int burst;
		k = 0;
		while (k < n) begin
			kind  = $urandom_range(0, 99);
			burst = $urandom_range(1, eff_line(lsize) + 2);
			for (int j = 0; j < burst && k < n; j++) begin
				a = any_access();
				if ($urandom_range(0, 3) != 0) a.peek = 6'($urandom_range(0, 15));
				if (kind < 18) begin
					a.func = tksd_pkg::FUNC_KEY;
					if ($urandom_range(0, 19) == 0) a.key = tksd_pkg::CH_NONE;
				end else if (kind < 34) begin
					a.func = tksd_pkg::FUNC_READ;
					if ($urandom_range(0, 3) != 0) a.reg_idx = tksd_pkg::REG_KEY_DATA;
				end else if (kind < 56) begin
					a.func = tksd_pkg::FUNC_WRITE;
					a.reg_idx = tksd_pkg::REG_SCR_DATA;
					a.wr[6] = 1'b1;
					if ($urandom_range(0, 19) == 0) a.wr = tksd_pkg::CH_NONE;
				end else if (kind < 74) begin
					a.func = tksd_pkg::FUNC_TICK;
				end else if (kind < 84) begin
					// newline, then ticks through the clear
					if (j == 0) begin
						a.func = tksd_pkg::FUNC_WRITE;
						a.reg_idx = tksd_pkg::REG_SCR_DATA;
						a.wr = tksd_pkg::CH_NEWLINE;
					end else begin
						a.func = tksd_pkg::FUNC_TICK;
					end
				end else if (kind < 88) begin
					a.func = tksd_pkg::FUNC_PEEK;
				end else if (kind < 90) begin
					a.func = tksd_pkg::FUNC_CLEAR;
					burst = 1;
				end
				access_q.push_back(a);
				k++;
			end
		end
	endtask

	task automatic wait_quiet();
		@(posedge clk);
		while (access_q.size() != 0 || s_tvalid || reply_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_line_size(input logic [6:0] v);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen <= 1'b0;
		lsize = 32'(v);
	endtask

	// run control
	initial begin
		logic [6:0] sizes[9];
		sizes = '{7'd3, 7'd127, 7'd5, 7'd0, 7'd64, 7'd2, 7'd9, 7'd1, 7'd17};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: register map, extremes of the characters, special cases
		add_access(tksd_pkg::FUNC_READ, tksd_pkg::REG_KEY_DATA, 8'd0, 8'd0, 6'd0);
		add_access(tksd_pkg::FUNC_READ, tksd_pkg::REG_KEY_STAT, 8'd0, 8'd0, 6'd0);
		add_access(tksd_pkg::FUNC_READ, tksd_pkg::REG_SCR_DATA, 8'd0, 8'd0, 6'd0);
		add_access(tksd_pkg::FUNC_READ, tksd_pkg::REG_SCR_STAT, 8'd0, 8'd0, 6'd0);
		add_access(tksd_pkg::FUNC_WRITE, tksd_pkg::REG_KEY_DATA, 8'h41, 8'd0, 6'd0);
		add_access(tksd_pkg::FUNC_WRITE, tksd_pkg::REG_KEY_STAT, 8'h41, 8'd0, 6'd0);
		add_access(tksd_pkg::FUNC_WRITE, tksd_pkg::REG_SCR_STAT, 8'h41, 8'd0, 6'd0);
		add_access(tksd_pkg::FUNC_KEY, tksd_pkg::REG_KEY_DATA, 8'd0, tksd_pkg::CH_NONE,
			6'd0);
		add_access(tksd_pkg::FUNC_KEY, tksd_pkg::REG_KEY_DATA, 8'd0, 8'hFF, 6'd0);
		add_access(tksd_pkg::FUNC_KEY, tksd_pkg::REG_KEY_DATA, 8'd0, 8'h01, 6'd0);
		add_access(tksd_pkg::FUNC_READ, tksd_pkg::REG_KEY_DATA, 8'd0, 8'd0, 6'd0);
		add_access(tksd_pkg::FUNC_WRITE, tksd_pkg::REG_SCR_DATA, tksd_pkg::CH_NONE, 8'd0,
			6'd0);
		add_access(tksd_pkg::FUNC_WRITE, tksd_pkg::REG_SCR_DATA, 8'hFF, 8'd0, 6'd0);
		add_access(tksd_pkg::FUNC_WRITE, tksd_pkg::REG_SCR_DATA, 8'h01, 8'd0, 6'd1);
		add_access(tksd_pkg::FUNC_PEEK, tksd_pkg::REG_KEY_DATA, 8'd0, 8'd0, 6'd0);
		add_access(tksd_pkg::FUNC_PEEK, tksd_pkg::REG_KEY_DATA, 8'd0, 8'd0, 6'd63);
		add_access(tksd_pkg::FUNC_WRITE, tksd_pkg::REG_SCR_DATA, tksd_pkg::CH_NEWLINE,
			8'd0, 6'd0);
		add_access(tksd_pkg::FUNC_WRITE, tksd_pkg::REG_SCR_DATA, 8'h41, 8'd0, 6'd0);
		add_access(tksd_pkg::FUNC_READ, tksd_pkg::REG_SCR_STAT, 8'd0, 8'd0, 6'd0);
		add_access(tksd_pkg::FUNC_TICK, tksd_pkg::REG_KEY_DATA, 8'd0, 8'd0, 6'd0);
		add_access(tksd_pkg::FUNC_TICK, tksd_pkg::REG_KEY_DATA, 8'd0, 8'd0, 6'd0);
		add_access(tksd_pkg::FUNC_TICK, tksd_pkg::REG_KEY_DATA, 8'd0, 8'd0, 6'd0);
		add_access(FUNC_UNUSED_6, tksd_pkg::REG_KEY_DATA, 8'd0, 8'd0, 6'd0);
		add_access(FUNC_UNUSED_7, tksd_pkg::REG_KEY_DATA, 8'd0, 8'd0, 6'd0);
		add_access(tksd_pkg::FUNC_CLEAR, tksd_pkg::REG_KEY_DATA, 8'd0, 8'd0, 6'd0);
		add_access(tksd_pkg::FUNC_WRITE, tksd_pkg::REG_SCR_DATA, tksd_pkg::CH_NEWLINE,
			8'd0, 6'd0);
		add_access(tksd_pkg::FUNC_TICK, tksd_pkg::REG_KEY_DATA, 8'd0, 8'd0, 6'd0);
		wait_quiet();

		for (int p = 0; p < 9; p++) begin
			// idle pattern: sender-light, then receiver-light, then none
			if (p < 3) begin
				tx_idle_pct = 21;
				rx_idle_pct = 50;
			end else if (p < 6) begin
				tx_idle_pct = 50;
				rx_idle_pct = 21;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			set_line_size(sizes[p]);
			add_random(PHASE_ITEMS / 2);
			// long output stall while the sender keeps offering
			if (p == 0 || p == 4) hold_req = hold_req + 1;
			wait_quiet();
			add_random(PHASE_ITEMS - PHASE_ITEMS / 2);
			// fill both stores before the line size shrinks
			if (p == 4) begin
				for (int i = 0; i < 30; i++) begin
					add_access(tksd_pkg::FUNC_KEY, tksd_pkg::REG_KEY_DATA, 8'd0,
						8'($urandom_range(1, 255)), 6'($urandom_range(0, 63)));
					add_access(tksd_pkg::FUNC_WRITE, tksd_pkg::REG_SCR_DATA,
						8'($urandom_range(64, 255)), 8'd0, 6'($urandom_range(0, 63)));
				end
			end
			wait_quiet();
		end

		repeat (20) @(posedge clk);
		err_count = err_count + reply_q.size();
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/tksd_pkg.sv
hdl/tksd_ram.sv
hdl/tksd_cell.sv
hdl/terminal_keyboard_screen_device_core.sv
verif/tb_terminal_keyboard_screen_device_core.sv
